// File: hdl/cas_pkg.sv
// Shared types and constants for the contrast adaptive sharpening core.
`timescale 1ns / 1ps
package cas_pkg;

  localparam int PIX_W   = 8;
  localparam int CFG_W   = 11;
  localparam int ROW_W   = 11;
  localparam int AMT_W   = 9;
  localparam int SUM_W   = 10;
  localparam int WQ_W    = 14;
  localparam int PROD_W  = 24;

  // serial divider: 40-bit dividend/quotient shift register, 18-bit divisor
  localparam int DIV_DW  = 40;
  localparam int DIV_VW  = 18;
  localparam int DIV_CW  = 6;

  // serial square root: 33-bit radicand, 17-bit root
  localparam int SQ_W    = 33;
  localparam int ROOT_W  = 17;

  localparam logic [DIV_CW-1:0] STEPS_RATIO  = 6'd40;
  localparam logic [DIV_CW-1:0] STEPS_WEIGHT = 6'd25;
  localparam logic [DIV_CW-1:0] STEPS_ROUND  = 6'd26;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;
  localparam logic [1:0] REG_AMOUNT = 2'd3;

  localparam logic [PIX_W-1:0]  PIX_MAX    = 8'd255;
  localparam logic [AMT_W-1:0]  AMT_MAX    = 9'd256;
  localparam logic [11:0]       AMT_BASE   = 12'd2048;
  localparam logic [8:0]        SOFT_SPAN  = 9'd510;
  localparam logic [16:0]       DEN_ONE    = 17'h10000;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic              start;
    logic [DIV_CW-1:0] steps;
  } div_req_t;

endpackage

// File: hdl/cas_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cas_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/cas_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module cas_div (
  input  logic                          clk,
  input  logic                          rst,
  input  cas_pkg::div_req_t             req,
  input  logic [cas_pkg::DIV_DW-1:0]    dividend,
  input  logic [cas_pkg::DIV_VW-1:0]    divisor,
  output logic                          busy,
  output logic [cas_pkg::DIV_DW-1:0]    quotient
);

  logic [cas_pkg::DIV_DW-1:0] acc;
  logic [cas_pkg::DIV_VW-1:0] dvs;
  logic [cas_pkg::DIV_VW-1:0] rem;
  logic [cas_pkg::DIV_CW-1:0] cnt;
  logic [cas_pkg::DIV_VW:0]   trial;
  logic [cas_pkg::DIV_VW:0]   diff;
  logic                       fits;

  // dividend is pre-aligned to the top; quotient bits shift in at the bottom
  assign trial    = {rem, acc[cas_pkg::DIV_DW-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign diff     = trial - {1'b0, dvs};
  assign quotient = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= req.steps;
      acc  <= dividend;
      dvs  <= divisor;
      rem  <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= diff[cas_pkg::DIV_VW-1:0];
        acc <= {acc[cas_pkg::DIV_DW-2:0], 1'b1};
      end else begin
        rem <= trial[cas_pkg::DIV_VW-1:0];
        acc <= {acc[cas_pkg::DIV_DW-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == cas_pkg::DIV_CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/cas_sqrt.sv
// Digit-serial integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps
module cas_sqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [cas_pkg::SQ_W-1:0]     radicand,
  output logic                         busy,
  output logic [cas_pkg::ROOT_W-1:0]   root
);

  logic [cas_pkg::SQ_W-1:0] x;
  logic [cas_pkg::SQ_W-1:0] res;
  logic [cas_pkg::SQ_W-1:0] bitv;
  logic [cas_pkg::SQ_W:0]   trial;

  assign trial = {1'b0, res} + {1'b0, bitv};
  assign root  = res[cas_pkg::ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      x    <= radicand;
      res  <= '0;
      bitv <= {1'b1, {(cas_pkg::SQ_W-1){1'b0}}};
    end else if (busy) begin
      if ({1'b0, x} >= trial) begin
        x   <= x - trial[cas_pkg::SQ_W-1:0];
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
      if (bitv[0]) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/contrast_adaptive_sharpen_core.sv
// Top level of the contrast adaptive sharpening core: line store, window, sequencer.
// Latency: a pixel's result follows the input word that arrives frame_width + 1 pixels
//   later (or a fill word once the frame is complete).
// Pacing: one word is in work at a time; a word with a result holds the input, set by
//   the shared bit-serial divider (40 + 25 + 26 steps) and 17-step root, per channel.
//   A flat black window or a non-positive numerator skips divisions and ends sooner.
// Reset: synchronous; counters clear, registers return to width 1, height 1, colour, amount 0.
`timescale 1ns / 1ps
module contrast_adaptive_sharpen_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // chan_first, chan_second, chan_third
  input  logic        s_tuser,   // is_fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // res_first, res_second, res_third
  output logic        m_tlast,   // frame_end
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int EW    = CW + 1;
  localparam int LW    = CW + 2;
  localparam int DEPTH = 4 << CW;

  typedef logic [CW-1:0]              col_t;
  typedef logic [EW-1:0]              wid_t;
  typedef logic [LW-1:0]              lag_t;
  typedef logic [cas_pkg::ROW_W-1:0]  row_t;

  // sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CHECK = 4'd1;
  localparam logic [3:0] ST_READ  = 4'd2;
  localparam logic [3:0] ST_PREP  = 4'd3;
  localparam logic [3:0] ST_DIV1  = 4'd4;
  localparam logic [3:0] ST_SQ    = 4'd5;
  localparam logic [3:0] ST_DIV2  = 4'd6;
  localparam logic [3:0] ST_MUL   = 4'd7;
  localparam logic [3:0] ST_NUM   = 4'd8;
  localparam logic [3:0] ST_DIV3  = 4'd9;
  localparam logic [3:0] ST_OUT   = 4'd10;

  // neighbor kinds while the window streams out of the line store
  localparam logic [1:0] NB_CTR    = 2'd0;
  localparam logic [1:0] NB_CROSS  = 2'd1;
  localparam logic [1:0] NB_CORNER = 2'd2;

  localparam logic [3:0] K_LAST = 4'd9;

  // configuration
  logic [cas_pkg::CFG_W-1:0] frame_width;
  logic [cas_pkg::CFG_W-1:0] frame_height;
  logic                      color_mode;
  logic [cas_pkg::AMT_W-1:0] sharpen_amount;

  // stream position
  row_t row_count, out_row;
  col_t col_count, out_col;
  lag_t lag;           // words written minus results given

  logic [3:0] state;
  logic [3:0] k;
  logic [1:0] ch;

  logic       nb_use_d;
  logic [1:0] nb_kind_d;

  // per-channel window statistics
  cas_pkg::pix_t              ctr_l  [3];
  cas_pkg::pix_t              rmin_l [3];
  cas_pkg::pix_t              rmax_l [3];
  cas_pkg::pix_t              cmin_l [3];
  cas_pkg::pix_t              cmax_l [3];
  logic [cas_pkg::SUM_W-1:0]  sum_l  [3];
  cas_pkg::pix_t              res_l  [3];

  logic [cas_pkg::WQ_W-1:0]   wq;
  logic [cas_pkg::PROD_W-1:0] prod;

  // effective geometry and strength
  wid_t  weff;
  row_t  heff;
  logic [cas_pkg::AMT_W-1:0] amt;
  logic [11:0] amt_div;

  always_comb begin
    if (frame_width == '0) begin
      weff = wid_t'(1);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      weff = wid_t'(MAX_WIDTH);
    end else begin
      weff = wid_t'(frame_width);
    end
    heff    = (frame_height == '0) ? row_t'(1) : frame_height;
    amt     = (sharpen_amount > cas_pkg::AMT_MAX) ? cas_pkg::AMT_MAX : sharpen_amount;
    amt_div = cas_pkg::AMT_BASE - ({3'b0, amt} + {2'b0, amt, 1'b0});
  end

  // input side
  logic accept, write_ok, in_row_end, emit;
  lag_t lag_need;

  assign s_tready   = (state == ST_IDLE);
  assign accept     = s_tvalid && s_tready;
  // drop pixels beyond the frame and all fill words
  assign write_ok   = !s_tuser && (row_count < heff);
  assign in_row_end = ({1'b0, col_count} + wid_t'(1)) >= weff;
  assign lag_need   = lag_t'(weff) + lag_t'(2);
  // give a result once the pixel below-right is in, or the frame is complete
  assign emit       = ((row_count == heff) || (lag >= lag_need)) && (out_row < heff);

  // window addressing around the output pixel
  logic       up_ok, dn_ok, lf_ok, rt_ok;
  logic [1:0] r_c, r_u, r_d;
  col_t       c_l, c_r;
  logic [1:0] nb_row;
  col_t       nb_col;
  logic       nb_ok;
  logic [1:0] nb_kind;
  logic       out_row_end, frame_end;

  assign up_ok       = out_row != '0;
  assign dn_ok       = (out_row + row_t'(1)) < heff;
  assign lf_ok       = out_col != '0;
  assign rt_ok       = ({1'b0, out_col} + wid_t'(1)) < weff;
  assign r_c         = out_row[1:0];
  assign r_u         = r_c - 2'd1;
  assign r_d         = r_c + 2'd1;
  assign c_l         = out_col - col_t'(1);
  assign c_r         = out_col + col_t'(1);
  assign out_row_end = ({1'b0, out_col} + wid_t'(1)) >= weff;
  assign frame_end   = out_row_end && ((out_row + row_t'(1)) == heff);

  always_comb begin
    nb_row  = r_c;
    nb_col  = out_col;
    nb_ok   = 1'b0;
    nb_kind = NB_CORNER;
    unique case (k)
      4'd0: begin nb_ok = 1'b1; nb_kind = NB_CTR; end
      4'd1: begin nb_row = r_u; nb_ok = up_ok; nb_kind = NB_CROSS; end
      4'd2: begin nb_col = c_l; nb_ok = lf_ok; nb_kind = NB_CROSS; end
      4'd3: begin nb_row = r_d; nb_ok = dn_ok; nb_kind = NB_CROSS; end
      4'd4: begin nb_col = c_r; nb_ok = rt_ok; nb_kind = NB_CROSS; end
      4'd5: begin nb_row = r_u; nb_col = c_l; nb_ok = up_ok && lf_ok; end
      4'd6: begin nb_row = r_u; nb_col = c_r; nb_ok = up_ok && rt_ok; end
      4'd7: begin nb_row = r_d; nb_col = c_l; nb_ok = dn_ok && lf_ok; end
      4'd8: begin nb_row = r_d; nb_col = c_r; nb_ok = dn_ok && rt_ok; end
      default: begin nb_ok = 1'b0; end
    endcase
  end

  // line store: four rows used as a ring by row number
  logic [23:0]   rd_data;
  cas_pkg::pix_t rd_lane [3];

  cas_ram #(
    .WIDTH (24),
    .DEPTH (DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (accept && write_ok),
    .waddr ({row_count[1:0], col_count}),
    .wdata (s_tdata),
    .raddr ({nb_row, nb_col}),
    .rdata (rd_data)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rd_lane[i] = rd_data[8*i +: 8];
    end
  end

  // current channel's statistics
  cas_pkg::pix_t             c_ctr, c_rmin, c_rmax, c_amin, c_amax;
  logic [cas_pkg::SUM_W-1:0] c_sum;
  logic [8:0]                mn, mx, inv, lim;
  logic                      ch_last;

  always_comb begin
    c_ctr  = ctr_l[ch];
    c_rmin = rmin_l[ch];
    c_rmax = rmax_l[ch];
    c_sum  = sum_l[ch];
    c_amin = (cmin_l[ch] < c_rmin) ? cmin_l[ch] : c_rmin;
    c_amax = (cmax_l[ch] > c_rmax) ? cmax_l[ch] : c_rmax;
    mn     = {1'b0, c_rmin} + {1'b0, c_amin};
    mx     = {1'b0, c_rmax} + {1'b0, c_amax};
    inv    = cas_pkg::SOFT_SPAN - mx;
    lim    = (mn < inv) ? mn : inv;
    ch_last = color_mode ? (ch == 2'd2) : 1'b1;
  end

  // final quotient operands: (2*numer + den) / (2*den)
  logic signed [24:0] numer;
  logic [16:0]        den;
  logic [25:0]        rnd_num;
  logic               numer_pos;

  assign numer     = $signed({1'b0, c_ctr, 16'b0}) - $signed({1'b0, prod});
  assign den       = cas_pkg::DEN_ONE - {1'b0, wq, 2'b00};
  assign numer_pos = !numer[24] && (numer != '0);
  assign rnd_num   = {1'b0, numer[23:0], 1'b0} + {9'b0, den};

  // shared arithmetic units
  cas_pkg::div_req_t           div_req;
  logic [cas_pkg::DIV_DW-1:0]  div_dividend, div_quot;
  logic [cas_pkg::DIV_VW-1:0]  div_divisor;
  logic                        div_busy;
  logic                        sq_start, sq_busy;
  logic [cas_pkg::ROOT_W-1:0]  sq_root;

  always_comb begin
    div_req.start = 1'b0;
    div_req.steps = '0;
    div_dividend  = '0;
    div_divisor   = '0;
    priority if (state == ST_PREP) begin
      // ratio = min(mn, 510 - mx) * 2^32 / mx
      div_req.start = mx != '0;
      div_req.steps = cas_pkg::STEPS_RATIO;
      div_dividend  = {lim[7:0], 32'b0};
      div_divisor   = {9'b0, mx};
    end else if (state == ST_SQ) begin
      // weight = root * 256 / (2048 - 3 * amount)
      div_req.start = !sq_busy;
      div_req.steps = cas_pkg::STEPS_WEIGHT;
      div_dividend  = {sq_root, 23'b0};
      div_divisor   = {6'b0, amt_div};
    end else if (state == ST_NUM) begin
      div_req.start = numer_pos;
      div_req.steps = cas_pkg::STEPS_ROUND;
      div_dividend  = {rnd_num, 14'b0};
      div_divisor   = {den, 1'b0};
    end else begin
      div_req.start = 1'b0;
    end
  end

  assign sq_start = (state == ST_DIV1) && !div_busy;

  cas_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  cas_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (div_quot[cas_pkg::SQ_W-1:0]),
    .busy     (sq_busy),
    .root     (sq_root)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      k              <= '0;
      ch             <= '0;
      row_count      <= '0;
      col_count      <= '0;
      out_row        <= '0;
      out_col        <= '0;
      lag            <= '0;
      m_tvalid       <= 1'b0;
      frame_width    <= cas_pkg::CFG_W'(1);
      frame_height   <= cas_pkg::CFG_W'(1);
      color_mode     <= 1'b1;
      sharpen_amount <= '0;
    end else begin
      // drop the result once taken
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (write_ok) begin
              lag <= lag + lag_t'(1);
              if (in_row_end) begin
                col_count <= '0;
                row_count <= row_count + row_t'(1);
              end else begin
                col_count <= col_count + col_t'(1);
              end
            end
            state <= ST_CHECK;
          end
        end

        ST_CHECK: begin
          k     <= '0;
          state <= emit ? ST_READ : ST_IDLE;
        end

        ST_READ: begin
          // issue one window read per cycle, fold the one read last cycle
          nb_use_d  <= nb_ok;
          nb_kind_d <= nb_kind;
          k         <= k + 4'd1;
          if (k == '0) begin
            for (int i = 0; i < 3; i++) begin
              res_l[i] <= '0;
            end
          end else if (nb_use_d) begin
            for (int i = 0; i < 3; i++) begin
              unique case (nb_kind_d)
                NB_CTR: begin
                  ctr_l[i]  <= rd_lane[i];
                  rmin_l[i] <= rd_lane[i];
                  rmax_l[i] <= rd_lane[i];
                  cmin_l[i] <= cas_pkg::PIX_MAX;
                  cmax_l[i] <= '0;
                  sum_l[i]  <= '0;
                end
                NB_CROSS: begin
                  if (rd_lane[i] < rmin_l[i]) rmin_l[i] <= rd_lane[i];
                  if (rd_lane[i] > rmax_l[i]) rmax_l[i] <= rd_lane[i];
                  sum_l[i] <= sum_l[i] + cas_pkg::SUM_W'(rd_lane[i]);
                end
                default: begin
                  if (rd_lane[i] < cmin_l[i]) cmin_l[i] <= rd_lane[i];
                  if (rd_lane[i] > cmax_l[i]) cmax_l[i] <= rd_lane[i];
                end
              endcase
            end
          end
          if (k == K_LAST) begin
            ch    <= '0;
            state <= ST_PREP;
          end
        end

        ST_PREP: begin
          // flat neighborhood with zero maximum: no sharpening
          if (mx == '0) begin
            wq    <= '0;
            state <= ST_MUL;
          end else begin
            state <= ST_DIV1;
          end
        end

        ST_DIV1: begin
          if (!div_busy) state <= ST_SQ;
        end

        ST_SQ: begin
          if (!sq_busy) state <= ST_DIV2;
        end

        ST_DIV2: begin
          if (!div_busy) begin
            wq    <= div_quot[cas_pkg::WQ_W-1:0];
            state <= ST_MUL;
          end
        end

        ST_MUL: begin
          prod  <= cas_pkg::PROD_W'(wq) * cas_pkg::PROD_W'(c_sum);
          state <= ST_NUM;
        end

        ST_NUM: begin
          if (numer_pos) begin
            state <= ST_DIV3;
          end else begin
            res_l[ch] <= '0;
            ch        <= ch + 2'd1;
            state     <= ch_last ? ST_OUT : ST_PREP;
          end
        end

        ST_DIV3: begin
          if (!div_busy) begin
            res_l[ch] <= (div_quot > cas_pkg::DIV_DW'(cas_pkg::PIX_MAX)) ?
                         cas_pkg::PIX_MAX : div_quot[cas_pkg::PIX_W-1:0];
            ch        <= ch + 2'd1;
            state     <= ch_last ? ST_OUT : ST_PREP;
          end
        end

        ST_OUT: begin
          // hold until the output register is free
          if (!m_tvalid) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {res_l[2], res_l[1], res_l[0]};
            m_tlast  <= frame_end;
            state    <= ST_IDLE;
            if (frame_end) begin
              row_count <= '0;
              col_count <= '0;
              out_row   <= '0;
              out_col   <= '0;
              lag       <= '0;
            end else begin
              lag <= lag - lag_t'(1);
              if (out_row_end) begin
                out_col <= '0;
                out_row <= out_row + row_t'(1);
              end else begin
                out_col <= out_col + col_t'(1);
              end
            end
          end
        end

        default: state <= ST_IDLE;
      endcase

      // configuration; width, height and mode writes restart the frame
      if (cfg_we) begin
        unique case (cfg_index)
          cas_pkg::REG_WIDTH:  frame_width    <= cfg_data;
          cas_pkg::REG_HEIGHT: frame_height   <= cfg_data;
          cas_pkg::REG_MODE:   color_mode     <= cfg_data[0];
          cas_pkg::REG_AMOUNT: sharpen_amount <= cfg_data[cas_pkg::AMT_W-1:0];
          default: ;
        endcase
        if (cfg_index != cas_pkg::REG_AMOUNT) begin
          row_count <= '0;
          col_count <= '0;
          out_row   <= '0;
          out_col   <= '0;
          lag       <= '0;
        end
      end
    end
  end

endmodule

// File: hdl/cas_check.sv
// Port-level checker for the sharpening core, bound to the top level.
`timescale 1ns / 1ps
module cas_check (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a word is still in work");

  a_out_gap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready |=> !m_tvalid)
    else $error("new result shown right after a take");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("block not idle after reset");

endmodule

bind contrast_adaptive_sharpen_core cas_check u_cas_check (.*);
